// ===== rtl/dttfp_pkg.sv =====
// Shared types, constants and codes for the decimal text to fixed-point block.
// Used by the controller, the datapath and the top level; depends on nothing.
package dttfp_pkg;

	localparam int MAX_DIGITS = 64;
	localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
	localparam int ADDR_W     = $clog2(MAX_DIGITS);
	localparam int DIGIT_W    = 4;
	localparam int EXP_W      = 16;
	localparam int SCL_W      = 18;

	localparam logic [EXP_W-1:0] EXP_LIMIT = 16'd32767;

	// parse phases
	localparam logic [1:0] PH_START      = 2'd0;
	localparam logic [1:0] PH_MANT       = 2'd1;
	localparam logic [1:0] PH_EXP_START  = 2'd2;
	localparam logic [1:0] PH_EXP_DIGITS = 2'd3;

	// characters
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_LOW_E = 8'h65;
	localparam logic [7:0] CH_UP_E  = 8'h45;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;

	localparam logic [63:0] ERROR_VALUE = 64'h8000_0000_0000_0000;

	typedef struct packed {
		logic [7:0] char_in;
		logic       last_char;
	} in_t;

	typedef struct packed {
		logic signed [63:0] value;
		logic               error;
	} out_t;

	// controller to datapath
	typedef struct packed {
		logic take;
		logic setup;
		logic acc;
		logic scale;
		logic finish;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic acc_done;
		logic scale_done;
		logic out_free;
	} stat_t;

endpackage

// ===== rtl/decimal_text_to_fixed_point.sv =====
// Top level of the decimal text to fixed-point converter.
// Depends on dttfp_pkg, dttfp_ctrl, dttfp_dp and dttfp_ram.

// Token bytes are taken one per cycle while the controller is idle; the input
// is held off from the byte marked last until the result is handed off. The
// conversion runs in order: setup; accumulation of the kept mantissa digits
// (one read per digit, one step for the digit store's registered read and one
// to see the last sum land); then scale-up, one decade per step (scale-up stops
// at the first overflow, so at most 19 decades); and the hand-off, which waits
// while the previous result still waits to be taken. The result register lets
// the next token start while a result waits to be taken.
module decimal_text_to_fixed_point (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [7:0]      cfg_wdata,
	input  logic            in_valid,
	output logic            in_ready,
	input  dttfp_pkg::in_t  in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output dttfp_pkg::out_t out_data
);
	import dttfp_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	dttfp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.last_char (in_data.last_char),
		.in_ready  (in_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	dttfp_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_data   (in_data),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// ===== rtl/dttfp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Self-contained; no package.
module dttfp_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/dttfp_ctrl.sv =====
// Controller state machine: sequences byte intake, setup, digit accumulation,
// scale-up and result hand-off. Depends on dttfp_pkg.
module dttfp_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             last_char,
	output logic             in_ready,
	input  dttfp_pkg::stat_t stat,
	output dttfp_pkg::cmd_t  cmd
);
	import dttfp_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SETUP = 3'd1;
	localparam logic [2:0] ST_ACC   = 3'd2;
	localparam logic [2:0] ST_SCALE = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	logic [2:0] state_q, state_d;

	// decode commands and next state
	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		cmd        = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.take = in_valid;
				if (in_valid && last_char)
					state_d = ST_SETUP;
			end
			ST_SETUP: begin
				cmd.setup = 1'b1;
				state_d   = ST_ACC;
			end
			ST_ACC: begin
				cmd.acc = 1'b1;
				if (stat.acc_done)
					state_d = ST_SCALE;
			end
			ST_SCALE: begin
				cmd.scale = 1'b1;
				if (stat.scale_done)
					state_d = ST_DONE;
			end
			ST_DONE: begin
				if (stat.out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

endmodule

// ===== rtl/dttfp_dp.sv =====
// Datapath: token parse registers, digit store, accumulator, scaler and the
// output register. Depends on dttfp_pkg and dttfp_ram.
module dttfp_dp (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [7:0]       cfg_wdata,
	input  dttfp_pkg::in_t   in_data,
	input  dttfp_pkg::cmd_t  cmd,
	output dttfp_pkg::stat_t stat,
	output logic             out_valid,
	input  logic             out_ready,
	output dttfp_pkg::out_t  out_data
);
	import dttfp_pkg::*;

	logic [7:0]       scale_q;
	logic [CNT_W-1:0] count_q, dot_q, keep_q, idx_q;
	logic             dot_seen_q, mneg_q, eneg_q, fault_q, bad_end_q;
	logic [1:0]       phase_q;
	logic [EXP_W-1:0] exp_q;
	logic signed [SCL_W-1:0] s_q;
	logic [63:0]      r_q;
	logic             ovf_q, rd_vld_s1;

	// byte classification and next parse state
	logic [7:0]       d8;
	logic             is_digit, be, wr;
	logic [1:0]       phase_d;
	logic [CNT_W-1:0] count_d, dot_d;
	logic             dot_seen_d, mneg_d, eneg_d, fault_d;
	logic [EXP_W-1:0] exp_d;
	logic [18:0]      exp_x;
	logic [3:0]       ram_rdata;

	assign d8       = in_data.char_in - CH_ZERO;
	assign is_digit = d8 < 8'd10;
	assign exp_x    = {3'd0, exp_q} * 19'd10 + {15'd0, d8[3:0]};

	always_comb begin
		phase_d    = phase_q;
		count_d    = count_q;
		dot_d      = dot_q;
		dot_seen_d = dot_seen_q;
		mneg_d     = mneg_q;
		eneg_d     = eneg_q;
		exp_d      = exp_q;
		fault_d    = fault_q;
		be         = 1'b0;
		wr         = 1'b0;
		if (!fault_q) begin
			priority if (phase_q == PH_START && in_data.char_in == CH_MINUS) begin
				phase_d = PH_MANT;
				mneg_d  = 1'b1;
				be      = 1'b1;
			end else if (phase_q == PH_START || phase_q == PH_MANT) begin
				phase_d = PH_MANT;
				priority if (is_digit) begin
					if (count_q >= CNT_W'(MAX_DIGITS))
						fault_d = 1'b1;
					else begin
						wr      = 1'b1;
						count_d = count_q + 1'b1;
					end
				end else if (in_data.char_in == CH_DOT) begin
					if (dot_seen_q)
						fault_d = 1'b1;
					else begin
						dot_seen_d = 1'b1;
						dot_d      = count_q;
					end
				end else if (in_data.char_in == CH_LOW_E || in_data.char_in == CH_UP_E) begin
					phase_d = PH_EXP_START;
					be      = 1'b1;
				end else
					fault_d = 1'b1;
			end else if (phase_q == PH_EXP_START && in_data.char_in == CH_MINUS) begin
				phase_d = PH_EXP_DIGITS;
				eneg_d  = 1'b1;
				be      = 1'b1;
			end else if (phase_q == PH_EXP_START && in_data.char_in == CH_PLUS) begin
				phase_d = PH_EXP_DIGITS;
				be      = 1'b1;
			end else begin
				phase_d = PH_EXP_DIGITS;
				if (!is_digit)
					fault_d = 1'b1;
				else begin
					exp_d = exp_x[EXP_W-1:0];
					if (exp_x > {3'd0, EXP_LIMIT})
						fault_d = 1'b1;
				end
			end
		end
	end

	// scale and keep count at setup
	logic signed [SCL_W-1:0] s_calc, drop;
	logic [CNT_W-1:0]        keep_calc;
	always_comb begin
		s_calc = SCL_W'(scale_q);
		s_calc = eneg_q ? s_calc - SCL_W'(exp_q) : s_calc + SCL_W'(exp_q);
		if (dot_seen_q)
			s_calc = s_calc - SCL_W'(count_q - dot_q);
		drop      = -s_calc;
		keep_calc = count_q;
		if (s_calc < 0)
			keep_calc = (drop >= SCL_W'(count_q)) ? '0 : count_q - drop[CNT_W-1:0];
	end

	// accumulate step r*10 + d and scale step r*10
	logic [67:0] acc_sum, scl_sum;
	logic        rd_en;
	assign acc_sum = {1'b0, r_q, 3'b0} + {3'b0, r_q, 1'b0} + {64'd0, ram_rdata};
	assign scl_sum = {1'b0, r_q, 3'b0} + {3'b0, r_q, 1'b0};
	assign rd_en   = cmd.acc && (idx_q != keep_q);

	dttfp_ram #(.WIDTH(DIGIT_W), .DEPTH(MAX_DIGITS)) u_store (
		.clk   (clk),
		.we    (cmd.take && wr),
		.waddr (count_q[ADDR_W-1:0]),
		.wdata (d8[3:0]),
		.re    (rd_en),
		.raddr (idx_q[ADDR_W-1:0]),
		.rdata (ram_rdata)
	);

	assign stat.acc_done   = (idx_q == keep_q) && !rd_vld_s1;
	assign stat.scale_done = (s_q <= 0) || (r_q == 64'd0) || ovf_q;
	assign stat.out_free   = !out_valid || out_ready;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			scale_q <= '0;
		else if (cfg_we)
			scale_q <= cfg_wdata;
	end

	// parse state: advance on a transaction, clear when the result is handed off
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_START;
			count_q    <= '0;
			dot_q      <= '0;
			dot_seen_q <= 1'b0;
			mneg_q     <= 1'b0;
			eneg_q     <= 1'b0;
			exp_q      <= '0;
			fault_q    <= 1'b0;
			bad_end_q  <= 1'b0;
		end else if (cmd.finish) begin
			phase_q    <= PH_START;
			count_q    <= '0;
			dot_q      <= '0;
			dot_seen_q <= 1'b0;
			mneg_q     <= 1'b0;
			eneg_q     <= 1'b0;
			exp_q      <= '0;
			fault_q    <= 1'b0;
			bad_end_q  <= 1'b0;
		end else if (cmd.take) begin
			phase_q    <= phase_d;
			count_q    <= count_d;
			dot_q      <= dot_d;
			dot_seen_q <= dot_seen_d;
			mneg_q     <= mneg_d;
			eneg_q     <= eneg_d;
			exp_q      <= exp_d;
			fault_q    <= fault_d;
			bad_end_q  <= be;
		end
	end

	// setup, accumulate and scale
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
			idx_q     <= '0;
			keep_q    <= '0;
			ovf_q     <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_en;
			if (cmd.setup) begin
				idx_q  <= '0;
				keep_q <= keep_calc;
				ovf_q  <= 1'b0;
			end else begin
				if (rd_en)
					idx_q <= idx_q + 1'b1;
				if (cmd.acc && rd_vld_s1 && acc_sum[67:63] != 5'd0)
					ovf_q <= 1'b1;
				if (cmd.scale && !stat.scale_done && scl_sum[67:63] != 5'd0)
					ovf_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.setup) begin
			s_q <= s_calc;
			r_q <= '0;
		end else if (cmd.acc && rd_vld_s1) begin
			r_q <= acc_sum[63:0];
		end else if (cmd.scale && !stat.scale_done) begin
			r_q <= scl_sum[63:0];
			s_q <= s_q - 1'b1;
		end
	end

	// output register: load on finish, drop on a transaction
	logic err;
	assign err = fault_q || bad_end_q || ovf_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (cmd.finish)
			out_valid <= 1'b1;
		else if (out_ready)
			out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_data.error <= err;
			out_data.value <= err ? ERROR_VALUE : (mneg_q ? 64'd0 - r_q : r_q);
		end
	end

endmodule
